>>> rtl/ltdp_pkg.sv
package ltdp_pkg;

	// Field widths of the token and byte channels
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int DIST_W = 14;
	localparam int LEN_W  = 9;
	localparam int NEG_W  = 13;

	// Descriptor word
	localparam int             DESC_BITS = 16;
	localparam logic [4:0]     BITS_FULL = 5'd16;

	// Token classification limits
	localparam logic [LEN_W-1:0]  LEN_MIN        = 9'd2;
	localparam logic [LEN_W-1:0]  SHORT_MAX_LEN  = 9'd5;
	localparam logic [LEN_W-1:0]  MID_MAX_LEN    = 9'd9;
	localparam logic [DIST_W-1:0] DIST_MIN       = 14'd1;
	localparam logic [DIST_W-1:0] SHORT_MAX_DIST = 14'd256;

	// Byte constants
	localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;
	localparam logic [BYTE_W-1:0] TERM_HI      = 8'hF0;
	localparam logic [BYTE_W-1:0] DIST_HI_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEN_LO_MASK  = 8'h07;

	typedef enum logic [1:0] {
		KIND_LIT   = 2'd0,
		KIND_MATCH = 2'd1,
		KIND_FIN   = 2'd2,
		KIND_RSVD  = 2'd3
	} kind_t;

	// Token class, fixed at accept time
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_LIT,
		CLS_SHORT,
		CLS_MID,
		CLS_LONG,
		CLS_FIN
	} cls_t;

	// Micro-operations
	typedef enum logic [1:0] {
		OP_NOP,
		OP_BIT,
		OP_BYTE,
		OP_FLUSH
	} uop_t;

	typedef enum logic [1:0] {
		BSRC_ZERO,
		BSRC_ONE,
		BSRC_LEN1,
		BSRC_LEN0
	} bsrc_t;

	typedef enum logic [2:0] {
		YSRC_LIT,
		YSRC_NEG_LO,
		YSRC_MID_HI,
		YSRC_DIST_HI,
		YSRC_LEN_M1,
		YSRC_ZERO,
		YSRC_TERM_HI
	} ysrc_t;

	typedef enum logic {
		COND_NEXT,
		COND_IF_LONG
	} cond_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// Program entry points and the long-match jump target
	localparam upc_t UPC_LIT   = 5'd0;
	localparam upc_t UPC_SHORT = 5'd2;
	localparam upc_t UPC_MID   = 5'd7;
	localparam upc_t UPC_LONG  = 5'd11;
	localparam upc_t UPC_FIN   = 5'd13;

	typedef struct packed {
		uop_t  op;
		bsrc_t bit_src;
		ysrc_t byte_src;
		logic  mark;
		cond_t cond;
		upc_t  target;
		logic  done;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		logic  exec;
		uop_t  op;
		bsrc_t bit_src;
		ysrc_t byte_src;
		logic  mark;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic busy;
		cls_t cls;
	} stat_t;

	function automatic uword_t uw(uop_t op, bsrc_t bs, ysrc_t ys, logic mark,
			cond_t cond, upc_t target, logic done);
		uword_t w;
		w.op       = op;
		w.bit_src  = bs;
		w.byte_src = ys;
		w.mark     = mark;
		w.cond     = cond;
		w.target   = target;
		w.done     = done;
		return w;
	endfunction

	// Control store. mark: a group flush raised by this step closes the item.
	function automatic uword_t ucode_rom(upc_t a);
		uword_t w;
		case (a)
			// literal
			5'd0:  w = uw(OP_BIT,  BSRC_ONE,  YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd1:  w = uw(OP_BYTE, BSRC_ZERO, YSRC_LIT,     1'b1, COND_NEXT, UPC_LIT, 1'b1);
			// short match
			5'd2:  w = uw(OP_BIT,  BSRC_ZERO, YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd3:  w = uw(OP_BIT,  BSRC_ZERO, YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd4:  w = uw(OP_BIT,  BSRC_LEN1, YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd5:  w = uw(OP_BIT,  BSRC_LEN0, YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd6:  w = uw(OP_BYTE, BSRC_ZERO, YSRC_NEG_LO,  1'b1, COND_NEXT, UPC_LIT, 1'b1);
			// mid match, long match branches off after the low distance byte
			5'd7:  w = uw(OP_BIT,  BSRC_ZERO, YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd8:  w = uw(OP_BIT,  BSRC_ONE,  YSRC_ZERO,    1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd9:  w = uw(OP_BYTE, BSRC_ZERO, YSRC_NEG_LO,  1'b1, COND_IF_LONG, UPC_LONG,
					1'b0);
			5'd10: w = uw(OP_BYTE, BSRC_ZERO, YSRC_MID_HI,  1'b1, COND_NEXT, UPC_LIT, 1'b1);
			5'd11: w = uw(OP_BYTE, BSRC_ZERO, YSRC_DIST_HI, 1'b1, COND_NEXT, UPC_LIT, 1'b0);
			5'd12: w = uw(OP_BYTE, BSRC_ZERO, YSRC_LEN_M1,  1'b1, COND_NEXT, UPC_LIT, 1'b1);
			// finish: terminator match, then final flush
			5'd13: w = uw(OP_BIT,  BSRC_ZERO, YSRC_ZERO,    1'b0, COND_NEXT, UPC_LIT, 1'b0);
			5'd14: w = uw(OP_BIT,  BSRC_ONE,  YSRC_ZERO,    1'b0, COND_NEXT, UPC_LIT, 1'b0);
			5'd15: w = uw(OP_BYTE, BSRC_ZERO, YSRC_ZERO,    1'b0, COND_NEXT, UPC_LIT, 1'b0);
			5'd16: w = uw(OP_BYTE, BSRC_ZERO, YSRC_TERM_HI, 1'b0, COND_NEXT, UPC_LIT, 1'b0);
			5'd17: w = uw(OP_BYTE, BSRC_ZERO, YSRC_ZERO,    1'b0, COND_NEXT, UPC_LIT, 1'b0);
			5'd18: w = uw(OP_FLUSH, BSRC_ZERO, YSRC_ZERO,   1'b1, COND_NEXT, UPC_LIT, 1'b1);
			default: w = uw(OP_NOP, BSRC_ZERO, YSRC_ZERO,   1'b0, COND_NEXT, UPC_LIT, 1'b1);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/ltdp_if.sv
// Token channel
interface ltdp_tok_if;
	import ltdp_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [BYTE_W-1:0]   literal_value;
	logic [DIST_W-1:0]   distance;
	logic [LEN_W-1:0]    length;

	modport source (output valid, output kind, output literal_value, output distance,
		output length, input ready);
	modport sink (input valid, input kind, input literal_value, input distance,
		input length, output ready);
endinterface

// Compressed byte channel
interface ltdp_byte_if;
	import ltdp_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/lz_token_descriptor_packer.sv
// LZ token packer: turns literal, match and finish tokens into a descriptor-bit /
// data-byte stream, sent as bytes on the byte channel. A token is taken and
// classified, dispatched in a decode state and then run by a small microprogram at
// one step per cycle while no group is being sent (literal 2 steps, short match 5,
// mid match 4, long match 5, finish 6). When the sixteenth descriptor bit lands, the
// group is sent out: descriptor low byte, high byte, then the buffered group bytes,
// one byte per cycle through the single output port while the receiver takes them.
// The program waits while the group is taken and its bytes are issued; a group
// buffers at most about two dozen bytes. Finish adds the terminator match, sends the
// partial group right-aligned and returns the group state to its reset values. The
// last byte of a group carries last = 1 unless a terminator-match bit of finish
// closed the group. The group buffer needs no clearing after reset.
module lz_token_descriptor_packer #(
	parameter int GROUP_BUFFER_DEPTH = 32,
	parameter int MAX_DISTANCE       = 8192,
	parameter int MAX_LENGTH         = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	ltdp_tok_if.sink    token,
	ltdp_byte_if.source stream
);
	import ltdp_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic  seq_idle;
	logic  tok_acc;

	assign token.ready = seq_idle && !stat.busy;
	assign tok_acc     = token.valid && token.ready;

	ltdp_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_acc (tok_acc),
		.stat    (stat),
		.ctrl    (ctrl),
		.idle    (seq_idle)
	);

	ltdp_dpath #(
		.GROUP_BUFFER_DEPTH (GROUP_BUFFER_DEPTH),
		.MAX_DISTANCE       (MAX_DISTANCE),
		.MAX_LENGTH         (MAX_LENGTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_acc       (tok_acc),
		.kind          (token.kind),
		.literal_value (token.literal_value),
		.distance      (token.distance),
		.length        (token.length),
		.ctrl          (ctrl),
		.stat          (stat),
		.out_valid     (stream.valid),
		.out_ready     (stream.ready),
		.out_byte      (stream.out_byte),
		.out_last      (stream.last)
	);

	// no micro-step may touch group state while a group is being sent
	a_step_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |-> !stat.busy)
		else $error("micro-step executed during group flush");

	// the cycle after an accept is spent classifying the item
	a_decode_gap: assert property (@(posedge clk) disable iff (!arst_n)
		tok_acc |=> !ctrl.exec)
		else $error("micro-step executed in the classify cycle");

	// a final flush step must hold off the next item
	a_flush_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.exec && ctrl.op == OP_FLUSH) |=> (stat.busy && !token.ready))
		else $error("final flush did not block the token channel");

endmodule

>>> rtl/ltdp_ram.sv
module ltdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/ltdp_useq.sv
module ltdp_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_acc,
	input  ltdp_pkg::stat_t stat,
	output ltdp_pkg::ctrl_t ctrl,
	output logic            idle
);
	import ltdp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RUN
	} state_t;

	state_t state_q;
	upc_t   upc_q;
	uword_t word;

	assign word = ucode_rom(upc_q);

	// control word out to the datapath; a step waits while a group drains
	always_comb begin
		ctrl.exec     = (state_q == ST_RUN) && !stat.busy;
		ctrl.op       = word.op;
		ctrl.bit_src  = word.bit_src;
		ctrl.byte_src = word.byte_src;
		ctrl.mark     = word.mark;
	end

	assign idle = (state_q == ST_IDLE);

	// step counter with entry dispatch and conditional jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			upc_q   <= UPC_LIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tok_acc) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_RUN;
					case (stat.cls)
						CLS_LIT:   upc_q <= UPC_LIT;
						CLS_SHORT: upc_q <= UPC_SHORT;
						CLS_MID:   upc_q <= UPC_MID;
						CLS_LONG:  upc_q <= UPC_MID;
						CLS_FIN:   upc_q <= UPC_FIN;
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_RUN: begin
					if (!stat.busy) begin
						if (word.done) begin
							state_q <= ST_IDLE;
						end else if (word.cond == COND_IF_LONG && stat.cls == CLS_LONG) begin
							upc_q <= word.target;
						end else begin
							upc_q <= upc_q + upc_t'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/ltdp_dpath.sv
module ltdp_dpath #(
	parameter int GROUP_BUFFER_DEPTH = 32,
	parameter int MAX_DISTANCE       = 8192,
	parameter int MAX_LENGTH         = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         tok_acc,
	input  logic [ltdp_pkg::KIND_W-1:0]  kind,
	input  logic [ltdp_pkg::BYTE_W-1:0]  literal_value,
	input  logic [ltdp_pkg::DIST_W-1:0]  distance,
	input  logic [ltdp_pkg::LEN_W-1:0]   length,
	input  ltdp_pkg::ctrl_t              ctrl,
	output ltdp_pkg::stat_t              stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ltdp_pkg::BYTE_W-1:0]  out_byte,
	output logic                         out_last
);
	import ltdp_pkg::*;

	localparam int DEPTH = GROUP_BUFFER_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(DEPTH + 2);
	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(MAX_DISTANCE);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LENGTH);
	localparam logic [CW-1:0]     CNT_MAX  = CW'(DEPTH);

	// token operands
	logic [DIST_W-1:0] dist_sat;
	logic [LEN_W-1:0]  len_sat;
	logic [DIST_W-1:0] neg_full;
	logic [LEN_W-1:0]  len_m1;
	logic [LEN_W-1:0]  len_m2;
	logic              is_short;
	cls_t              cls_c;
	cls_t              cls_q;
	logic [BYTE_W-1:0] lit_q;
	logic [NEG_W-1:0]  neg_q;
	logic [BYTE_W-1:0] lenm1_q;
	logic [2:0]        lenm2_q;

	// group state
	logic [DESC_BITS-1:0] desc_q;
	logic [4:0]           bits_left_q;
	logic [4:0]           bl_dec;
	logic [CW-1:0]        count_q;
	logic                 bit_val;
	logic [BYTE_W-1:0]    byte_val;
	logic [BYTE_W-1:0]    dist_hi;
	logic [DESC_BITS-1:0] desc_aligned;

	// flush request and byte issue
	logic                 flush_req_q;
	logic                 flush_final_q;
	logic                 flush_mark_q;
	logic                 flush_start;
	logic                 emit_active_q;
	logic [IW-1:0]        emit_idx_q;
	logic [CW-1:0]        emit_total_q;
	logic [DESC_BITS-1:0] emit_desc_q;
	logic                 emit_mark_q;
	logic                 idx_last;
	logic [IW-1:0]        ram_ra;
	logic                 issue_move;

	// issue -> s1 -> output register
	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 use_ram_s1;
	logic                 last_s1;
	logic                 s1_move;
	logic                 out_free;
	logic [BYTE_W-1:0]    ram_rd;
	logic                 ram_we;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_last_q;

	// saturate and classify the incoming token
	always_comb begin
		if (distance < DIST_MIN) begin
			dist_sat = DIST_MIN;
		end else if (distance > DIST_MAX) begin
			dist_sat = DIST_MAX;
		end else begin
			dist_sat = distance;
		end
		if (length < LEN_MIN) begin
			len_sat = LEN_MIN;
		end else if (length > LEN_MAX) begin
			len_sat = LEN_MAX;
		end else begin
			len_sat = length;
		end
		neg_full = {DIST_W{1'b0}} - dist_sat;
		len_m1   = len_sat - LEN_W'(1);
		len_m2   = len_sat - LEN_MIN;
		is_short = (len_sat <= SHORT_MAX_LEN) && (dist_sat <= SHORT_MAX_DIST);
		case (kind_t'(kind))
			KIND_LIT:   cls_c = CLS_LIT;
			KIND_MATCH: cls_c = is_short ? CLS_SHORT :
				((len_sat > MID_MAX_LEN) ? CLS_LONG : CLS_MID);
			KIND_FIN:   cls_c = CLS_FIN;
			default:    cls_c = CLS_NONE;
		endcase
	end

	// descriptor bit and data byte selected by the control word
	always_comb begin
		dist_hi = BYTE_W'(neg_q >> 5) & DIST_HI_MASK;
		case (ctrl.bit_src)
			BSRC_ZERO: bit_val = 1'b0;
			BSRC_ONE:  bit_val = 1'b1;
			BSRC_LEN1: bit_val = lenm2_q[1];
			BSRC_LEN0: bit_val = lenm2_q[0];
			default:   bit_val = 1'b0;
		endcase
		case (ctrl.byte_src)
			YSRC_LIT:     byte_val = lit_q;
			YSRC_NEG_LO:  byte_val = neg_q[BYTE_W-1:0];
			YSRC_MID_HI:  byte_val = dist_hi | ({5'd0, lenm2_q} & LEN_LO_MASK);
			YSRC_DIST_HI: byte_val = dist_hi;
			YSRC_LEN_M1:  byte_val = lenm1_q;
			YSRC_ZERO:    byte_val = ZERO_BYTE;
			YSRC_TERM_HI: byte_val = TERM_HI;
			default:      byte_val = ZERO_BYTE;
		endcase
	end

	// descriptor right-aligned by the bits still free; an empty group sends zero
	assign desc_aligned = (bits_left_q >= BITS_FULL) ? {DESC_BITS{1'b0}} :
		(desc_q >> bits_left_q[3:0]);
	assign bl_dec = (bits_left_q != 5'd0) ? (bits_left_q - 5'd1) : 5'd0;

	assign flush_start = flush_req_q && !emit_active_q;
	assign out_free    = !out_valid_q || out_ready;
	assign s1_move     = valid_s1 && out_free;
	assign issue_move  = emit_active_q && (!valid_s1 || s1_move);
	assign idx_last    = (emit_idx_q == (IW'(emit_total_q) + IW'(1)));
	assign ram_ra      = emit_idx_q - IW'(2);
	assign ram_we      = ctrl.exec && (ctrl.op == OP_BYTE) && (count_q < CNT_MAX);

	assign stat.busy = flush_req_q || emit_active_q;
	assign stat.cls  = cls_q;

	ltdp_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_group_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (byte_val),
		.rd_en   (issue_move),
		.rd_addr (ram_ra[AW-1:0]),
		.rd_data (ram_rd)
	);

	// group state, flush control and emit pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q         <= CLS_NONE;
			desc_q        <= '0;
			bits_left_q   <= BITS_FULL;
			count_q       <= '0;
			flush_req_q   <= 1'b0;
			flush_final_q <= 1'b0;
			flush_mark_q  <= 1'b0;
			emit_active_q <= 1'b0;
			emit_idx_q    <= '0;
			emit_total_q  <= '0;
			emit_mark_q   <= 1'b0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (tok_acc) begin
				cls_q <= cls_c;
			end

			// one micro-step
			if (ctrl.exec) begin
				case (ctrl.op)
					OP_BIT: begin
						desc_q      <= {bit_val, desc_q[DESC_BITS-1:1]};
						bits_left_q <= bl_dec;
						if (bl_dec == 5'd0) begin
							flush_req_q   <= 1'b1;
							flush_final_q <= 1'b0;
							flush_mark_q  <= ctrl.mark;
						end
					end
					OP_BYTE: begin
						if (count_q < CNT_MAX) begin
							count_q <= count_q + CW'(1);
						end
					end
					OP_FLUSH: begin
						flush_req_q   <= 1'b1;
						flush_final_q <= 1'b1;
						flush_mark_q  <= ctrl.mark;
					end
					default: ;
				endcase
			end

			// snapshot the group and open a new one
			if (flush_start) begin
				flush_req_q   <= 1'b0;
				emit_active_q <= 1'b1;
				emit_idx_q    <= '0;
				emit_total_q  <= count_q;
				emit_mark_q   <= flush_mark_q;
				count_q       <= '0;
				bits_left_q   <= BITS_FULL;
				if (flush_final_q) begin
					desc_q <= '0;
				end
			end

			// walk descriptor low, high, then buffered bytes
			if (issue_move) begin
				if (idx_last) begin
					emit_active_q <= 1'b0;
				end else begin
					emit_idx_q <= emit_idx_q + IW'(1);
				end
			end

			if (issue_move) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (tok_acc) begin
			lit_q   <= literal_value;
			neg_q   <= neg_full[NEG_W-1:0];
			lenm1_q <= len_m1[BYTE_W-1:0];
			lenm2_q <= len_m2[2:0];
		end
		if (flush_start) begin
			emit_desc_q <= desc_aligned;
		end
		if (issue_move) begin
			byte_s1    <= (emit_idx_q == '0) ? emit_desc_q[BYTE_W-1:0] :
				emit_desc_q[DESC_BITS-1:BYTE_W];
			use_ram_s1 <= (emit_idx_q >= IW'(2));
			last_s1    <= emit_mark_q && idx_last;
		end
		if (s1_move) begin
			out_byte_q <= use_ram_s1 ? ram_rd : byte_s1;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
